FILE: hdl/fawb_pkg.sv
// shared types and constants of the fully associative write-back cache
package fawb_pkg;

    localparam int NUM_LINES      = 8;
    localparam int BYTES_PER_LINE = 4;
    localparam int NUM_BLOCKS     = 32;
    localparam int LINE_W         = $clog2(NUM_LINES);
    localparam int OFF_W          = $clog2(BYTES_PER_LINE);
    localparam int BLK_W          = $clog2(NUM_BLOCKS);
    localparam int STORE_BYTES    = NUM_BLOCKS * BYTES_PER_LINE;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int LINE_BYTES     = NUM_LINES * BYTES_PER_LINE;
    localparam int LB_ADDR_W      = LINE_W + OFF_W;
    localparam int CNT_W          = 32;

    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_PRELOAD = 2'd2;

    typedef struct packed {
        logic [1:0]        operation;
        logic [ADDR_W-1:0] address;
        logic [7:0]        write_data;
    } t_in;

    typedef struct packed {
        logic             hit;
        logic [LINE_W-1:0] line_index;
        logic [7:0]       read_data;
        logic             wrote_back;
        logic [BLK_W-1:0] victim_block;
        logic [CNT_W-1:0] read_hit_count;
        logic [CNT_W-1:0] read_miss_count;
        logic [CNT_W-1:0] write_hit_count;
        logic [CNT_W-1:0] write_miss_count;
    } t_out;

    // tag array lookup result
    typedef struct packed {
        logic              hit;
        logic [LINE_W-1:0] hit_line;
        logic [LINE_W-1:0] victim_line;
        logic              victim_dirty;
        logic [BLK_W-1:0]  victim_tag;
    } t_tag_lookup;

    // tag array update
    typedef struct packed {
        logic              fill;
        logic              set_dirty;
        logic [LINE_W-1:0] line;
        logic [BLK_W-1:0]  tag;
    } t_tag_cmd;

    typedef struct packed {
        logic inc;
        logic is_write;
        logic is_hit;
    } t_stat_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] read_hits;
        logic [CNT_W-1:0] read_misses;
        logic [CNT_W-1:0] write_hits;
        logic [CNT_W-1:0] write_misses;
    } t_counts;

endpackage

FILE: hdl/fully_assoc_fifo_writeback_cache.sv
// top level: sequencer, line data memory and backing store memory
// A fully associative write-back cache of 8 lines of 4 bytes in front of a
// 128-byte backing store kept inside the block. After reset the block zeroes
// the backing store, one byte a cycle, with o_in_ready low. One transaction
// is handled at a time. A preload or an unused operation code goes from the
// lookup straight to loading the result, and a hit passes through one hit
// step first. A miss is paced by the byte-wide ports of the two memories:
// after the lookup, a dirty victim's bytes go out and the new block's bytes
// come in side by side, one byte each per cycle, then come a step for the
// last write, the final byte update and loading the result. The result is
// loaded only once the output register is free, and the next transaction is
// accepted after that. Replacement is fifo: a fill pointer walks the lines in
// order, so the oldest line is always the next victim. A result waits in the
// output register while the next transaction is accepted.
module fully_assoc_fifo_writeback_cache import fawb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_HIT,
        S_SWAP,
        S_SETTLE,
        S_UPDATE,
        S_FINISH
    } t_state;

    t_state             r_state;
    logic [1:0]         r_op;
    logic [ADDR_W-1:0]  r_addr;
    logic [7:0]         r_wdata;
    logic [LINE_W-1:0]  r_ln;
    logic               r_hit;
    logic [7:0]         r_rd;
    logic               r_wb;
    logic [BLK_W-1:0]   r_vic;
    logic [OFF_W-1:0]   r_j;
    logic               r_xfer_v;
    logic [OFF_W-1:0]   r_xfer_j;
    logic [ADDR_W-1:0]  r_clr;
    logic               r_out_valid;
    t_out               r_out;

    // memories
    logic [7:0]           r_line_mem  [LINE_BYTES];
    logic [7:0]           r_store_mem [STORE_BYTES];
    logic [7:0]           r_line_rdata;
    logic [7:0]           r_store_rdata;

    logic                 lm_we;
    logic [LB_ADDR_W-1:0] lm_waddr;
    logic [LB_ADDR_W-1:0] lm_raddr;
    logic [7:0]           lm_wdata;
    logic                 sm_we;
    logic [ADDR_W-1:0]    sm_waddr;
    logic [ADDR_W-1:0]    sm_raddr;
    logic [7:0]           sm_wdata;

    logic [BLK_W-1:0]     blk;
    logic [OFF_W-1:0]     off;
    logic                 is_write;
    logic                 out_free;

    t_tag_lookup          lk;
    t_tag_cmd             tag_cmd;
    t_stat_cmd            stat_cmd;
    t_counts              counts;

    assign blk      = r_addr[ADDR_W-1:OFF_W];
    assign off      = r_addr[OFF_W-1:0];
    assign is_write = (r_op == OP_WRITE);
    assign out_free = !r_out_valid || i_out_ready;

    fawb_tags u_tags (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_blk    (blk),
        .i_cmd    (tag_cmd),
        .o_lookup (lk)
    );

    fawb_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (stat_cmd),
        .o_counts (counts)
    );

    // memory port steering
    always_comb begin
        lm_we    = 1'b0;
        lm_waddr = {r_ln, off};
        lm_wdata = r_wdata;
        lm_raddr = {r_ln, r_j};
        sm_we    = 1'b0;
        sm_waddr = r_addr;
        sm_wdata = r_wdata;
        sm_raddr = {blk, r_j};

        // lookup reads the hit byte so it is registered and ready in the hit state
        if (r_state == S_LOOKUP) begin
            lm_raddr = {lk.hit_line, off};
        end

        // trailing half of the line swap: fill byte in, dirty victim byte out
        if (r_xfer_v) begin
            lm_we    = 1'b1;
            lm_waddr = {r_ln, r_xfer_j};
            lm_wdata = r_store_rdata;
            if (r_wb) begin
                sm_we    = 1'b1;
                sm_waddr = {r_vic, r_xfer_j};
                sm_wdata = r_line_rdata;
            end
        end

        case (r_state)
            S_CLEAR: begin
                sm_we    = 1'b1;
                sm_waddr = r_clr;
                sm_wdata = '0;
            end
            S_LOOKUP: begin
                if (r_op == OP_PRELOAD) begin
                    sm_we = 1'b1;
                end
            end
            S_HIT: begin
                // write hit stores only a changed byte
                if (is_write && (r_line_rdata != r_wdata)) begin
                    lm_we = 1'b1;
                end
            end
            S_UPDATE: begin
                if (is_write) begin
                    lm_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lm_we) begin
            r_line_mem[lm_waddr] <= lm_wdata;
        end
        r_line_rdata <= r_line_mem[lm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sm_we) begin
            r_store_mem[sm_waddr] <= sm_wdata;
        end
        r_store_rdata <= r_store_mem[sm_raddr];
    end

    // tag and counter updates
    always_comb begin
        tag_cmd  = '0;
        stat_cmd = '0;
        stat_cmd.is_write = is_write;
        case (r_state)
            S_LOOKUP: begin
                if (((r_op == OP_READ) || (r_op == OP_WRITE)) && !lk.hit) begin
                    tag_cmd.fill = 1'b1;
                    tag_cmd.line = lk.victim_line;
                    tag_cmd.tag  = blk;
                end
            end
            S_HIT: begin
                stat_cmd.inc    = 1'b1;
                stat_cmd.is_hit = 1'b1;
                tag_cmd.line    = r_ln;
                tag_cmd.set_dirty = is_write && (r_line_rdata != r_wdata);
            end
            S_UPDATE: begin
                stat_cmd.inc      = 1'b1;
                tag_cmd.line      = r_ln;
                tag_cmd.set_dirty = is_write;
            end
            default: begin
            end
        endcase
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_j         <= '0;
            r_xfer_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_xfer_v <= (r_state == S_SWAP);
            r_xfer_j <= r_j;

            // a result loaded this cycle keeps valid high
            if (r_out_valid && i_out_ready && !((r_state == S_FINISH) && out_free)) begin
                r_out_valid <= 1'b0;
            end

            // pick up the requested byte as the new block streams in
            if (r_xfer_v && (r_xfer_j == off)) begin
                r_rd <= r_store_rdata;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_data.operation;
                        r_addr  <= i_in_data.address;
                        r_wdata <= i_in_data.write_data;
                        r_state <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    r_hit <= 1'b0;
                    r_ln  <= '0;
                    r_rd  <= '0;
                    r_wb  <= 1'b0;
                    r_vic <= '0;
                    r_j   <= '0;
                    case (r_op)
                        OP_PRELOAD: begin
                            r_rd    <= r_wdata;
                            r_state <= S_FINISH;
                        end
                        OP_READ, OP_WRITE: begin
                            if (lk.hit) begin
                                r_hit   <= 1'b1;
                                r_ln    <= lk.hit_line;
                                r_state <= S_HIT;
                            end else begin
                                r_ln    <= lk.victim_line;
                                r_wb    <= lk.victim_dirty;
                                r_vic   <= lk.victim_dirty ? lk.victim_tag : '0;
                                r_state <= S_SWAP;
                            end
                        end
                        default: begin
                            r_state <= S_FINISH;
                        end
                    endcase
                end
                S_HIT: begin
                    r_rd    <= is_write ? r_wdata : r_line_rdata;
                    r_state <= S_FINISH;
                end
                S_SWAP: begin
                    r_j <= r_j + 1'b1;
                    if (r_j == OFF_W'(BYTES_PER_LINE - 1)) begin
                        r_state <= S_SETTLE;
                    end
                end
                S_SETTLE: begin
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (is_write) begin
                        r_rd <= r_wdata;
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    // result register, loaded as the transaction completes
                    if (out_free) begin
                        r_out_valid            <= 1'b1;
                        r_out.hit              <= r_hit;
                        r_out.line_index       <= r_ln;
                        r_out.read_data        <= r_rd;
                        r_out.wrote_back       <= r_wb;
                        r_out.victim_block     <= r_vic;
                        r_out.read_hit_count   <= counts.read_hits;
                        r_out.read_miss_count  <= counts.read_misses;
                        r_out.write_hit_count  <= counts.write_hits;
                        r_out.write_miss_count <= counts.write_misses;
                        r_state                <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: hdl/fawb_tags.sv
// tag, valid and dirty array with parallel match and fifo fill pointer
module fawb_tags import fawb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [BLK_W-1:0] i_blk,
    input  t_tag_cmd         i_cmd,
    output t_tag_lookup      o_lookup
);

    logic [NUM_LINES-1:0] r_valid;
    logic [NUM_LINES-1:0] r_dirty;
    logic [BLK_W-1:0]     r_tag [NUM_LINES];
    logic [LINE_W-1:0]    r_ptr;

    // lowest matching line wins
    always_comb begin
        o_lookup.hit      = 1'b0;
        o_lookup.hit_line = '0;
        for (int i = NUM_LINES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_tag[i] == i_blk)) begin
                o_lookup.hit      = 1'b1;
                o_lookup.hit_line = LINE_W'(i);
            end
        end
        o_lookup.victim_line  = r_ptr;
        o_lookup.victim_dirty = r_valid[r_ptr] & r_dirty[r_ptr];
        o_lookup.victim_tag   = r_tag[r_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_ptr   <= '0;
        end else begin
            if (i_cmd.fill) begin
                r_valid[i_cmd.line] <= 1'b1;
                r_dirty[i_cmd.line] <= 1'b0;
                r_ptr <= (r_ptr == LINE_W'(NUM_LINES - 1)) ? '0 : r_ptr + 1'b1;
            end else if (i_cmd.set_dirty) begin
                r_dirty[i_cmd.line] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            r_tag[i_cmd.line] <= i_cmd.tag;
        end
    end

endmodule

FILE: hdl/fawb_stats.sv
// saturating hit and miss counters
module fawb_stats import fawb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_stat_cmd i_cmd,
    output t_counts   o_counts
);

    t_counts r_counts;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counts <= '0;
        end else if (i_cmd.inc) begin
            case ({i_cmd.is_write, i_cmd.is_hit})
                2'b00:   r_counts.read_misses  <= sat_inc(r_counts.read_misses);
                2'b01:   r_counts.read_hits    <= sat_inc(r_counts.read_hits);
                2'b10:   r_counts.write_misses <= sat_inc(r_counts.write_misses);
                2'b11:   r_counts.write_hits   <= sat_inc(r_counts.write_hits);
                default: r_counts <= r_counts;
            endcase
        end
    end

    assign o_counts = r_counts;

endmodule
